// File: rtl/core/sorted_deadline_wakeup_queue_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted deadline wakeup queue.
// Every check is clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_WAKEUP_QUEUE_CORE_MACROS_SVH
`define SORTED_DEADLINE_WAKEUP_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define SDWQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sdwq_pkg.sv
// ----------------------------------------------------------------------------
// sdwq_pkg
// Shared types and constants for the sorted deadline wakeup queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdwq_pkg;

    // fixed port widths
    localparam int IN_ID_W    = 6;
    localparam int DUR_W      = 32;
    localparam int OUT_ID_W   = 6;
    localparam int OUT_TICK_W = 48;

    // most words released by one tick
    localparam int MAX_RESULTS = 16;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SLEEP = 1'b1;

    localparam logic ST_RELEASED = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;  // insert r_key / new id at its sorted place
        logic pop;  // shift everything one cell toward the head
    } t_cell_ctrl;

endpackage

// File: rtl/core/sdwq_cell.sv
// ----------------------------------------------------------------------------
// sdwq_cell
// One slot of the sorted queue. Holds a deadline and an id, compares its
// deadline with the broadcast key, and shifts with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdwq_cell
    import sdwq_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int QUEUE_DEPTH = 16,
    parameter int TICK_BITS   = 48,
    parameter int ID_BITS     = 6,
    localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [TICK_BITS-1:0] i_key,
    input  logic [ID_BITS-1:0]   i_new_id,
    input  logic [OCC_W-1:0]     i_occ,
    input  logic                 i_left_after,
    input  logic [TICK_BITS-1:0] i_left_dl,
    input  logic [ID_BITS-1:0]   i_left_id,
    input  logic [TICK_BITS-1:0] i_right_dl,
    input  logic [ID_BITS-1:0]   i_right_id,
    output logic                 o_after,
    output logic [TICK_BITS-1:0] o_dl,
    output logic [ID_BITS-1:0]   o_id
);

    logic [TICK_BITS-1:0] r_dl, n_dl;
    logic [ID_BITS-1:0]   r_id, n_id;

    // occupied and not later than the key: a new entry with that key goes behind
    assign o_after = (i_occ > OCC_W'(IDX)) && (r_dl <= i_key);

    always_comb begin
        n_dl = r_dl;
        n_id = r_id;
        if (i_ctrl.pop) begin
            n_dl = i_right_dl;
            n_id = i_right_id;
        end else if (i_ctrl.ins && !o_after) begin
            if (i_left_after) begin
                n_dl = i_key;
                n_id = i_new_id;
            end else begin
                n_dl = i_left_dl;
                n_id = i_left_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl <= n_dl;
        r_id <= n_id;
    end

    assign o_dl = r_dl;
    assign o_id = r_id;

endmodule

// File: rtl/core/sorted_deadline_wakeup_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_deadline_wakeup_queue_core
// Tick counter plus a chain of cells kept sorted by wakeup deadline.
//
//   channel   dir  handshake               payload
//   request   in   start & !busy           i_opcode, i_sleeper_id, i_duration
//   result    out  o_valid, one cycle      o_status, o_released_id,
//                                          o_tick_now, o_last
//
// Sleep released at once or rejected: result in the cycle after acceptance.
// Sleep queued: deadline add, then insert into the cell chain in S_INS.
// Tick: bump the counter, then S_POP checks the head and releases each due
//   word; the head pops one cell a cycle.
// Reset is synchronous; it empties the queue and zeroes the counter, cell
// contents are left as they are. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_deadline_wakeup_queue_core
    import sdwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICK_BITS   = 48,
    parameter int ID_BITS     = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_opcode,
    input  logic [IN_ID_W-1:0]      i_sleeper_id,
    input  logic signed [DUR_W-1:0] i_duration,
    output logic                    o_valid,
    output logic                    o_status,
    output logic [OUT_ID_W-1:0]     o_released_id,
    output logic [OUT_TICK_W-1:0]   o_tick_now,
    output logic                    o_last
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W = $clog2(MAX_RESULTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [TICK_BITS-1:0] r_tick, n_tick;
    logic [TICK_BITS-1:0] r_key, n_key;
    logic [OCC_W-1:0]     r_occ, n_occ;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [ID_BITS-1:0]   r_new_id, n_new_id;
    logic                 r_valid, n_valid;
    logic                 r_status, n_status;
    logic [OUT_ID_W-1:0]  r_o_id, n_o_id;
    logic                 r_last, n_last;

    logic                 w_accept;
    logic [ID_BITS-1:0]   w_in_id;
    logic [TICK_BITS:0]   w_sum;
    logic                 w_full;
    logic                 w_final;
    t_cell_ctrl           w_ctrl;

    logic                 w_after [QUEUE_DEPTH];
    logic [TICK_BITS-1:0] w_dl    [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   w_id    [QUEUE_DEPTH];

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_in_id  = ID_BITS'(i_sleeper_id);
    assign w_full   = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign w_sum    = {1'b0, r_tick} + (TICK_BITS + 1)'(unsigned'(i_duration));

    // in S_POP the key holds the new tick count, so w_after[0] means head is due
    assign w_final = (r_cnt == CNT_W'(MAX_RESULTS - 1)) || !w_after[1];

    assign w_ctrl.pop = (r_state == S_POP) && w_after[0];
    assign w_ctrl.ins = (r_state == S_INS);

    always_comb begin
        n_state  = r_state;
        n_tick   = r_tick;
        n_key    = r_key;
        n_occ    = r_occ;
        n_cnt    = r_cnt;
        n_new_id = r_new_id;
        n_valid  = 1'b0;
        n_status = r_status;
        n_o_id   = r_o_id;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_TICK) begin
                        // saturate, never wrap
                        n_tick  = (r_tick == '1) ? r_tick : r_tick + 1'b1;
                        n_key   = n_tick;
                        n_cnt   = '0;
                        n_state = S_POP;
                    end else if (i_duration <= 0 || w_full) begin
                        n_valid  = 1'b1;
                        n_status = (i_duration <= 0) ? ST_RELEASED : ST_REJECTED;
                        n_o_id   = OUT_ID_W'(w_in_id);
                        n_last   = 1'b1;
                    end else begin
                        n_key    = w_sum[TICK_BITS] ? '1 : w_sum[TICK_BITS-1:0];
                        n_new_id = w_in_id;
                        n_state  = S_INS;
                    end
                end
            end
            S_POP: begin
                if (w_after[0]) begin
                    n_valid  = 1'b1;
                    n_status = ST_RELEASED;
                    n_o_id   = OUT_ID_W'(w_id[0]);
                    n_last   = w_final;
                    n_occ    = r_occ - 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    if (w_final) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INS: begin
                n_occ   = r_occ + 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_new_id <= n_new_id;
        r_status <= n_status;
        r_o_id   <= n_o_id;
        r_last   <= n_last;
    end

    // output tick reflects the count when the word was produced
    logic [OUT_TICK_W-1:0] r_o_tick;
    always_ff @(posedge i_clk) begin
        r_o_tick <= OUT_TICK_W'(r_tick);
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                 w_l_after;
        logic [TICK_BITS-1:0] w_l_dl, w_r_dl;
        logic [ID_BITS-1:0]   w_l_id, w_r_id;

        if (g == 0) begin : g_head
            assign w_l_after = 1'b1;
            assign w_l_dl    = '0;
            assign w_l_id    = '0;
        end else begin : g_mid
            assign w_l_after = w_after[g-1];
            assign w_l_dl    = w_dl[g-1];
            assign w_l_id    = w_id[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_r_dl = '0;
            assign w_r_id = '0;
        end else begin : g_body
            assign w_r_dl = w_dl[g+1];
            assign w_r_id = w_id[g+1];
        end

        sdwq_cell #(
            .IDX         (g),
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .TICK_BITS   (TICK_BITS),
            .ID_BITS     (ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_key        (r_key),
            .i_new_id     (r_new_id),
            .i_occ        (r_occ),
            .i_left_after (w_l_after),
            .i_left_dl    (w_l_dl),
            .i_left_id    (w_l_id),
            .i_right_dl   (w_r_dl),
            .i_right_id   (w_r_id),
            .o_after      (w_after[g]),
            .o_dl         (w_dl[g]),
            .o_id         (w_id[g])
        );
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_released_id = r_o_id;
    assign o_tick_now    = r_o_tick;
    assign o_last        = r_last;

endmodule

// File: rtl/core/sdwq_checker.sv
// ----------------------------------------------------------------------------
// sdwq_checker
// Port-level checks for the sorted deadline wakeup queue, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_deadline_wakeup_queue_core_macros.svh"

module sdwq_checker
    import sdwq_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    i_opcode,
    input logic                    o_valid,
    input logic                    o_status,
    input logic                    o_last,
    input logic [OUT_TICK_W-1:0]   o_tick_now
);

    `SDWQ_ASSERT_SAME(a_reject_is_last, o_valid && (o_status == ST_REJECTED), o_last, "reject word not marked last")
    `SDWQ_ASSERT_NEXT(a_burst_continues, o_valid && !o_last, o_valid, "release burst ended without last")
    `SDWQ_ASSERT_SAME(a_tick_monotonic, o_valid && $past(o_valid), o_tick_now >= $past(o_tick_now), "tick count went backward")
    `SDWQ_ASSERT_NEXT(a_tick_goes_busy, start && !busy && (i_opcode == OP_TICK), busy, "tick accepted without going busy")

endmodule

bind sorted_deadline_wakeup_queue_core sdwq_checker u_sdwq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_opcode   (i_opcode),
    .o_valid    (o_valid),
    .o_status   (o_status),
    .o_last     (o_last),
    .o_tick_now (o_tick_now)
);

// File: test/sorted_deadline_wakeup_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_deadline_wakeup_queue_core_tb
// Drives tick and sleep commands into the wakeup queue and checks every
// released word against a local model: a tick counter plus a sorted list of
// sleeper alarms. Directed cases cover immediate release, deadline order,
// a full queue and the longest sleep; random traffic follows.
// ----------------------------------------------------------------------------

module sorted_deadline_wakeup_queue_core_tb;
    import sdwq_pkg::*;

    localparam int          QUEUE_SLOTS    = 16;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam logic [47:0] TICK_MAX       = '1;

    typedef struct packed {
        logic        status;
        logic [5:0]  sleeper;
        logic [47:0] stamp;
        logic        last;
    } t_wake_word;

    typedef struct {
        logic [47:0] deadline;
        logic [5:0]  sleeper;
    } t_alarm;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_opcode;
    logic [IN_ID_W-1:0]      i_sleeper_id;
    logic signed [DUR_W-1:0] i_duration;
    logic                    o_valid;
    logic                    o_status;
    logic [OUT_ID_W-1:0]     o_released_id;
    logic [OUT_TICK_W-1:0]   o_tick_now;
    logic                    o_last;

    t_wake_word  pending_wakes[$];
    t_alarm      alarms[$];
    logic [47:0] model_ticks;
    int          err_count;
    int          stall_cycles;
    bit          gaps_on;

    sorted_deadline_wakeup_queue_core #(
        .QUEUE_DEPTH(QUEUE_SLOTS),
        .TICK_BITS  (48),
        .ID_BITS    (6)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_sleeper_id (i_sleeper_id),
        .i_duration   (i_duration),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_released_id(o_released_id),
        .o_tick_now   (o_tick_now),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // alarm model: advance on one accepted command, queue up the words it releases
    function automatic void model_cmd(logic op, logic [5:0] id, logic signed [31:0] dur);
        logic [48:0] sum;
        int          pos;
        int          n;
        t_alarm      a;
        if (op == OP_TICK) begin
            if (model_ticks != TICK_MAX) model_ticks++;
            n = 0;
            while (n < MAX_RESULTS && alarms.size() > 0 && alarms[0].deadline <= model_ticks) begin
                pending_wakes.push_back('{ST_RELEASED, alarms[0].sleeper, model_ticks, 1'b0});
                void'(alarms.pop_front());
                n++;
            end
            if (n > 0) pending_wakes[pending_wakes.size()-1].last = 1'b1;
        end else if (dur <= 0) begin
            pending_wakes.push_back('{ST_RELEASED, id, model_ticks, 1'b1});
        end else if (alarms.size() >= QUEUE_SLOTS) begin
            pending_wakes.push_back('{ST_REJECTED, id, model_ticks, 1'b1});
        end else begin
            sum = {1'b0, model_ticks} + {17'b0, dur};
            a.deadline = (sum > {1'b0, TICK_MAX}) ? TICK_MAX : sum[47:0];
            a.sleeper  = id;
            pos = 0;
            // equal deadlines keep arrival order
            while (pos < alarms.size() && alarms[pos].deadline <= a.deadline) pos++;
            alarms.insert(pos, a);
        end
    endfunction

    // drop start and put noise on the idle command fields
    task automatic rest(int cycles);
        @(negedge i_clk);
        start        <= 1'b0;
        i_opcode     <= 1'($urandom);
        i_sleeper_id <= 6'($urandom);
        i_duration   <= $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic issue_cmd(logic op, logic [5:0] id, logic signed [31:0] dur);
        if (gaps_on && $urandom_range(0, 3) == 0) rest($urandom_range(1, 10));
        @(negedge i_clk);
        start        <= 1'b1;
        i_opcode     <= op;
        i_sleeper_id <= id;
        i_duration   <= dur;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        model_cmd(op, id, dur);
    endtask

    task automatic wait_for_wakes();
        rest(1);
        while (pending_wakes.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_wake_word want;
        if (i_rst_n && o_valid) begin
            if (pending_wakes.size() == 0) begin
                $display("%0t: unexpected word, id %0d status %0d", $time,
                         o_released_id, o_status);
                err_count++;
            end else begin
                want = pending_wakes.pop_front();
                check_field("status", 48'(want.status), 48'(o_status));
                check_field("released_id", 48'(want.sleeper), 48'(o_released_id));
                check_field("tick_now", want.stamp, o_tick_now);
                check_field("last", 48'(want.last), 48'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic test_immediate_release();
        issue_cmd(OP_SLEEP, 6'd0, 32'sd0);
        issue_cmd(OP_SLEEP, 6'd63, -32'sd1);
        issue_cmd(OP_SLEEP, 6'd42, 32'sh8000_0000);
    endtask

    task automatic test_deadline_order();
        issue_cmd(OP_SLEEP, 6'd5, 32'sd3);
        issue_cmd(OP_SLEEP, 6'd6, 32'sd1);
        issue_cmd(OP_SLEEP, 6'd7, 32'sd3);
        issue_cmd(OP_SLEEP, 6'd8, 32'sd2);
        repeat (3) issue_cmd(OP_TICK, 6'($urandom), $urandom);
    endtask

    // fill every slot with one deadline, overflow, then release all in one tick
    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_SLOTS; i++) issue_cmd(OP_SLEEP, 6'(i), 32'sd2);
        issue_cmd(OP_SLEEP, 6'd63, 32'sd1);
        issue_cmd(OP_TICK, 6'd0, 32'sd0);
        issue_cmd(OP_TICK, 6'd63, 32'shFFFF_FFFF);
        wait_for_wakes();
    endtask

    // parks one slot for the rest of the run
    task automatic test_max_duration();
        issue_cmd(OP_SLEEP, 6'd21, 32'sh7FFF_FFFF);
        issue_cmd(OP_TICK, 6'd21, 32'sd0);
    endtask

    task automatic test_random_traffic(int count);
        logic signed [31:0] dur;
        int                 sel;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 45) begin
                issue_cmd(OP_TICK, 6'($urandom), $urandom);
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 15)      dur = $urandom | 32'h8000_0000;
                else if (sel < 20) dur = 0;
                else if (sel < 21) dur = $urandom & 32'h7FFF_FFFF;
                else               dur = $urandom_range(1, 20);
                issue_cmd(OP_SLEEP, 6'($urandom_range(0, 63)), dur);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_opcode     = OP_TICK;
        i_sleeper_id = '0;
        i_duration   = '0;
        model_ticks  = '0;
        gaps_on      = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_immediate_release();
        test_deadline_order();
        test_full_queue();
        test_max_duration();
        test_random_traffic(300);
        gaps_on = 1'b0;
        test_random_traffic(100);

        wait_for_wakes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sdwq_pkg.sv
rtl/core/sdwq_cell.sv
rtl/core/sorted_deadline_wakeup_queue_core.sv
rtl/core/sdwq_checker.sv
test/sorted_deadline_wakeup_queue_core_tb.sv
